[hw/rtl/ternary_cfc_ffn_neuron_unit_assert.svh]
// Assertion macros for the ternary recurrent FFN neuron unit.
`ifndef TERNARY_CFC_FFN_NEURON_UNIT_ASSERT_SVH
`define TERNARY_CFC_FFN_NEURON_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk and disabled in reset.
`define TCFN_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and disabled in reset.
`define TCFN_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/tcfn_pkg.sv]
// Shared types and constants of the ternary recurrent FFN neuron unit.
package tcfn_pkg;

  localparam int LANES    = 4;
  localparam int ACT_W    = 24;
  localparam int SUM_W    = 40;

  // Weight codes
  localparam logic [1:0] W_PLUS  = 2'd1;
  localparam logic [1:0] W_MINUS = 2'd2;

  // Result modes (anything else acts as the plain gate dot)
  localparam logic [1:0] MODE_RNN   = 2'd0;
  localparam logic [1:0] MODE_GATED = 2'd1;

  localparam logic signed [41:0] SUM_HI = 42'sd549755813887;
  localparam logic signed [41:0] SUM_LO = -42'sd549755813888;

  // 27 in Q24, the constant term of the tanh rational
  localparam logic [29:0] C27 = 30'd452984832;

  typedef enum logic [4:0] {
    ST_CLEAR, ST_IDLE, ST_RD, ST_HP, ST_SIGX_H, ST_S_SET, ST_S_WB,
    ST_X2_SET, ST_X2_WB, ST_NUM_SET, ST_NUM_WB, ST_DIV, ST_T_WB,
    ST_P1_SET, ST_P1_WB, ST_P2_SET, ST_P2_WB, ST_P3_SET, ST_P3_WB, ST_HN,
    ST_SIGX_G, ST_SG_SET, ST_SG_WB, ST_SIL_SET, ST_SIL_WB, ST_OUT_SET,
    ST_OUT, ST_MUL
  } state_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_CLEAR, OP_RD, OP_HP, OP_SIGX_H, OP_SIGX_G,
    OP_M_SIG, OP_M_X2, OP_M_NUM, OP_M_P1, OP_M_P2, OP_M_P3, OP_M_SIL, OP_M_OUT,
    OP_MUL, OP_W_S, OP_W_SG, OP_W_X2, OP_W_NUM, OP_DIV, OP_W_T,
    OP_W_P1, OP_W_P2, OP_W_P3, OP_W_HN, OP_W_SIL, OP_W_OUT
  } dp_op_t;

  typedef struct packed {
    logic   accept;
    dp_op_t op;
  } ctl_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic mul_last;
    logic div_last;
    logic tanh_sat;
    logic out_free;
  } dp_stat_t;

  // One lane of a saturating ternary accumulate
  function automatic logic signed [SUM_W-1:0] lane_acc(
    input logic signed [SUM_W-1:0] s,
    input logic signed [ACT_W-1:0] a,
    input logic [1:0]              code
  );
    logic signed [41:0] t;
    begin
      case (code)
        W_PLUS:  t = 42'(s) + 42'(a);
        W_MINUS: t = 42'(s) - 42'(a);
        default: t = 42'(s);
      endcase
      if (t > SUM_HI) t = SUM_HI;
      else if (t < SUM_LO) t = SUM_LO;
      lane_acc = t[SUM_W-1:0];
    end
  endfunction

endpackage

[hw/rtl/tcfn_ram.sv]
// Generic simple dual-port RAM with registered read.
module tcfn_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 65536
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic                                  re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[hw/rtl/tcfn_ctrl.sv]
// Sequencer for the row finish: clearing pass, accept, and datapath steps.
module tcfn_ctrl
  import tcfn_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  input  logic     last,
  input  logic [1:0] mode,
  output logic     in_stall,
  output ctl_cmd_t cmd,
  input  dp_stat_t stat
);

  state_t     state, state_next;
  state_t     ret, ret_next;
  logic [1:0] mode_r;

  // State, return point and row mode
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_CLEAR;
      ret    <= ST_IDLE;
      mode_r <= MODE_RNN;
    end else begin
      state <= state_next;
      ret   <= ret_next;
      if (cmd.accept && last) begin
        mode_r <= mode;
      end
    end
  end

  assign in_stall = (state != ST_IDLE);

  // Next state and datapath command
  always_comb begin
    state_next = state;
    ret_next   = ret;
    cmd.accept = 1'b0;
    cmd.op     = OP_NONE;
    case (state)
      ST_CLEAR: begin
        cmd.op = OP_CLEAR;
        if (stat.clr_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        cmd.accept = in_valid;
        if (in_valid && last) begin
          case (mode)
            MODE_RNN:   state_next = ST_RD;
            MODE_GATED: state_next = ST_SIGX_G;
            default:    state_next = ST_OUT;
          endcase
        end
      end
      ST_RD: begin
        cmd.op = OP_RD;
        state_next = ST_HP;
      end
      ST_HP: begin
        cmd.op = OP_HP;
        state_next = ST_SIGX_H;
      end
      ST_SIGX_H: begin
        cmd.op = OP_SIGX_H;
        state_next = ST_S_SET;
      end
      ST_S_SET: begin
        cmd.op = OP_M_SIG;
        ret_next = ST_S_WB;
        state_next = ST_MUL;
      end
      ST_S_WB: begin
        cmd.op = OP_W_S;
        state_next = stat.tanh_sat ? ST_T_WB : ST_X2_SET;
      end
      ST_X2_SET: begin
        cmd.op = OP_M_X2;
        ret_next = ST_X2_WB;
        state_next = ST_MUL;
      end
      ST_X2_WB: begin
        cmd.op = OP_W_X2;
        state_next = ST_NUM_SET;
      end
      ST_NUM_SET: begin
        cmd.op = OP_M_NUM;
        ret_next = ST_NUM_WB;
        state_next = ST_MUL;
      end
      ST_NUM_WB: begin
        cmd.op = OP_W_NUM;
        state_next = ST_DIV;
      end
      ST_DIV: begin
        cmd.op = OP_DIV;
        if (stat.div_last) state_next = ST_T_WB;
      end
      ST_T_WB: begin
        cmd.op = OP_W_T;
        state_next = ST_P1_SET;
      end
      ST_P1_SET: begin
        cmd.op = OP_M_P1;
        ret_next = ST_P1_WB;
        state_next = ST_MUL;
      end
      ST_P1_WB: begin
        cmd.op = OP_W_P1;
        state_next = ST_P2_SET;
      end
      ST_P2_SET: begin
        cmd.op = OP_M_P2;
        ret_next = ST_P2_WB;
        state_next = ST_MUL;
      end
      ST_P2_WB: begin
        cmd.op = OP_W_P2;
        state_next = ST_P3_SET;
      end
      ST_P3_SET: begin
        cmd.op = OP_M_P3;
        ret_next = ST_P3_WB;
        state_next = ST_MUL;
      end
      ST_P3_WB: begin
        cmd.op = OP_W_P3;
        state_next = ST_HN;
      end
      ST_HN: begin
        cmd.op = OP_W_HN;
        state_next = ST_SIGX_G;
      end
      ST_SIGX_G: begin
        cmd.op = OP_SIGX_G;
        state_next = ST_SG_SET;
      end
      ST_SG_SET: begin
        cmd.op = OP_M_SIG;
        ret_next = ST_SG_WB;
        state_next = ST_MUL;
      end
      ST_SG_WB: begin
        cmd.op = OP_W_SG;
        state_next = ST_SIL_SET;
      end
      ST_SIL_SET: begin
        cmd.op = OP_M_SIL;
        ret_next = ST_SIL_WB;
        state_next = ST_MUL;
      end
      ST_SIL_WB: begin
        cmd.op = OP_W_SIL;
        state_next = ST_OUT_SET;
      end
      ST_OUT_SET: begin
        if (mode_r == MODE_RNN || mode_r == MODE_GATED) begin
          cmd.op = OP_M_OUT;
          ret_next = ST_OUT;
          state_next = ST_MUL;
        end else begin
          state_next = ST_OUT;
        end
      end
      ST_OUT: begin
        if (stat.out_free) begin
          cmd.op = OP_W_OUT;
          state_next = ST_IDLE;
        end
      end
      ST_MUL: begin
        cmd.op = OP_MUL;
        if (stat.mul_last) state_next = ret;
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

[hw/rtl/tcfn_dp.sv]
// Datapath: row sums, hidden store, shared multiplier, divider and result register.
module tcfn_dp
  import tcfn_pkg::*;
#(
  parameter int ROW_COUNT   = 4096,
  parameter int LAYER_COUNT = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  ctl_cmd_t           cmd,
  output dp_stat_t           stat,
  input  logic [1:0]         mode,
  input  logic signed [23:0] act_0,
  input  logic signed [23:0] act_1,
  input  logic signed [23:0] act_2,
  input  logic signed [23:0] act_3,
  input  logic [7:0]         gate_trits,
  input  logic [7:0]         up_trits,
  input  logic [3:0]         layer_index,
  input  logic [11:0]        row_index,
  input  logic [15:0]        decay_factor,
  input  logic signed [15:0] neuron_bias,
  input  logic               last,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] value,
  output logic [3:0]         layer_out,
  output logic [11:0]        row_out
);

  localparam int DEPTH = LAYER_COUNT * ROW_COUNT;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // Row sums and captured row parameters
  logic signed [39:0] gate_sum, up_sum, gate_sum_next, up_sum_next;
  logic [1:0]         mode_r;
  logic [3:0]         layer_r;
  logic [11:0]        row_r;
  logic [15:0]        decay_r;
  logic signed [15:0] bias_r;

  // Hidden store access
  logic [AW-1:0]      clr_addr, hs_addr, ram_waddr;
  logic               ram_we, ok;
  logic [15:0]        ram_wdata, ram_rdata;

  // Scratch registers of the finish
  logic signed [15:0] hp;
  logic signed [43:0] sx;
  logic [14:0]        s_r, sg_r;
  logic [27:0]        x2;
  logic signed [15:0] t_r;
  logic [30:0]        p1;
  logic               p1neg;
  logic signed [47:0] t1;
  logic signed [48:0] acc_r;
  logic signed [15:0] hn_r;
  logic signed [40:0] sil;

  // Shared multiplier
  logic [39:0]        ma;
  logic [47:0]        mb;
  logic [87:0]        macc;
  logic [1:0]         mdig;
  logic               msign;
  logic [15:0]        mdigit;
  logic [55:0]        pp;
  logic [87:0]        pp_sh;

  // Restoring divider
  logic [46:0]        drem, dsh;
  logic [15:0]        dq;
  logic [3:0]         dcnt;
  logic [30:0]        den;
  logic               dfit;

  // Derived values
  logic [39:0]        up_abs, gate_abs, sil_abs;
  logic [15:0]        hp_abs, hn_abs;
  logic [14:0]        t_abs;
  logic [17:0]        sx_abs;
  logic               sx_lo, sx_hi;
  logic [87:0]        sig_sum, sil_sum, out_sum, out_mag;
  logic [14:0]        sig_r, sig_val;
  logic [48:0]        acc_abs, hn_sum;
  logic [18:0]        hn_mag;
  logic signed [15:0] hn_val;
  logic signed [31:0] out_val;
  logic signed [48:0] term2;

  // Saturating ternary accumulate over the four lanes
  always_comb begin
    gate_sum_next = gate_sum;
    up_sum_next   = up_sum;
    gate_sum_next = lane_acc(gate_sum_next, act_0, gate_trits[1:0]);
    gate_sum_next = lane_acc(gate_sum_next, act_1, gate_trits[3:2]);
    gate_sum_next = lane_acc(gate_sum_next, act_2, gate_trits[5:4]);
    gate_sum_next = lane_acc(gate_sum_next, act_3, gate_trits[7:6]);
    if (mode == MODE_RNN || mode == MODE_GATED) begin
      up_sum_next = lane_acc(up_sum_next, act_0, up_trits[1:0]);
      up_sum_next = lane_acc(up_sum_next, act_1, up_trits[3:2]);
      up_sum_next = lane_acc(up_sum_next, act_2, up_trits[5:4]);
      up_sum_next = lane_acc(up_sum_next, act_3, up_trits[7:6]);
    end
  end

  // Magnitudes
  assign up_abs   = up_sum[39]   ? 40'(-up_sum)   : 40'(up_sum);
  assign gate_abs = gate_sum[39] ? 40'(-gate_sum) : 40'(gate_sum);
  assign sil_abs  = sil[40]      ? 40'(-sil)      : 40'(sil);
  assign hp_abs   = hp[15]       ? 16'(-hp)       : 16'(hp);
  assign hn_abs   = hn_r[15]     ? 16'(-hn_r)     : 16'(hn_r);
  assign t_abs    = t_r[15]      ? 15'(-t_r)      : 15'(t_r);
  assign sx_abs   = sx[43]       ? 18'(-sx)       : 18'(sx);
  assign sx_lo    = (sx < -44'sd131072);
  assign sx_hi    = (sx > 44'sd131072);

  // Hidden store address; out-of-range rows read zero and are not written
  assign ok = (32'(layer_r) < LAYER_COUNT) && (32'(row_r) < ROW_COUNT);
  assign hs_addr = AW'(32'(layer_r) * ROW_COUNT + 32'(row_r));

  // Sigmoid from the product of x and (8 - |x|), with both clamps
  always_comb begin
    sig_sum = macc + 88'(1 << 20);
    sig_r   = sig_sum[35:21];
    if (sx_lo)      sig_val = 15'd0;
    else if (sx_hi) sig_val = 15'd16384;
    else if (msign) sig_val = 15'd8192 - sig_r;
    else            sig_val = 15'd8192 + sig_r;
  end

  // New hidden value: round Q44 to Q14, clamp to 16 bits
  always_comb begin
    acc_abs = acc_r[48] ? 49'(-acc_r) : 49'(acc_r);
    hn_sum  = acc_abs + 49'(1 << 29);
    hn_mag  = hn_sum[48:30];
    if (acc_r[48]) hn_val = (hn_mag >= 19'd32768) ? -16'sd32768 : 16'(-hn_mag[15:0]);
    else           hn_val = (hn_mag > 19'd32767) ? 16'sd32767 : 16'(hn_mag[15:0]);
  end

  // Product term of the candidate input, signed and scaled to Q44
  assign term2 = msign ? -49'($signed({20'd0, macc[28:0]} <<< 16))
                       :  49'($signed({20'd0, macc[28:0]} <<< 16));

  // Result rounding and 32-bit saturation
  always_comb begin
    sil_sum = macc + 88'(1 << 13);
    if (mode_r == MODE_RNN) begin
      out_sum = macc + 88'(1 << 13);
      out_mag = out_sum >> 14;
    end else begin
      out_sum = macc + 88'(1 << 11);
      out_mag = out_sum >> 12;
    end
    if (mode_r == MODE_RNN || mode_r == MODE_GATED) begin
      if (msign) out_val = (out_mag > 88'h8000_0000) ? 32'sh8000_0000
                                                     : 32'(-out_mag[31:0]);
      else       out_val = (out_mag > 88'h7FFF_FFFF) ? 32'sh7FFF_FFFF
                                                     : 32'(out_mag[31:0]);
    end else begin
      if (gate_sum > 40'sd2147483647)       out_val = 32'sh7FFF_FFFF;
      else if (gate_sum < -40'sd2147483648) out_val = 32'sh8000_0000;
      else                                  out_val = gate_sum[31:0];
    end
  end

  // Multiplier digit: 40 x 16 per cycle, three digits
  always_comb begin
    case (mdig)
      2'd0:    mdigit = mb[15:0];
      2'd1:    mdigit = mb[31:16];
      2'd2:    mdigit = mb[47:32];
      default: mdigit = 16'd0;
    endcase
    pp = 56'(ma) * 56'(mdigit);
    case (mdig)
      2'd0:    pp_sh = 88'(pp);
      2'd1:    pp_sh = 88'(pp) << 16;
      2'd2:    pp_sh = 88'(pp) << 32;
      default: pp_sh = 88'd0;
    endcase
  end

  // Divider helpers
  assign den  = 31'(C27) + 31'({x2, 3'b000}) + 31'(x2);
  assign dfit = (drem >= dsh);

  // Hidden store write port: clearing pass or new hidden value
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = hs_addr;
    ram_wdata = 16'(hn_val);
    if (cmd.op == OP_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr;
      ram_wdata = 16'd0;
    end else if (cmd.op == OP_W_HN) begin
      ram_we = ok;
    end
  end

  tcfn_ram #(
    .WIDTH (16),
    .DEPTH (DEPTH)
  ) u_hidden (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (cmd.op == OP_RD),
    .raddr (hs_addr),
    .rdata (ram_rdata)
  );

  // Status back to the sequencer
  always_comb begin
    stat.clr_last = (clr_addr == AW'(DEPTH - 1));
    stat.mul_last = (mdig == 2'd2);
    stat.div_last = (dcnt == 4'd0);
    stat.tanh_sat = (up_sum < -40'sd12288) || (up_sum > 40'sd12288);
    stat.out_free = !out_valid || !out_stall;
  end

  // Control state: sums, clear sweep, result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      gate_sum  <= '0;
      up_sum    <= '0;
      clr_addr  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.op == OP_W_OUT) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (cmd.accept) begin
        gate_sum <= gate_sum_next;
        up_sum   <= up_sum_next;
      end
      if (cmd.op == OP_CLEAR) begin
        clr_addr <= clr_addr + AW'(1);
      end
      if (cmd.op == OP_W_OUT) begin
        gate_sum  <= '0;
        up_sum    <= '0;
      end
    end
  end

  // Payload: captured row fields and finish registers
  always_ff @(posedge clk) begin
    if (cmd.accept && last) begin
      mode_r  <= mode;
      layer_r <= layer_index;
      row_r   <= row_index;
      decay_r <= decay_factor;
      bias_r  <= neuron_bias;
    end
    case (cmd.op)
      OP_HP:     hp <= ok ? $signed(ram_rdata) : 16'sd0;
      OP_SIGX_H: sx <= $signed({up_sum[39], up_sum, 3'b000}) + 44'(hp)
                       + 44'($signed({bias_r, 1'b0}));
      OP_SIGX_G: sx <= $signed({gate_sum[39], gate_sum, 3'b000});
      OP_M_SIG, OP_M_X2, OP_M_NUM, OP_M_P1, OP_M_P2, OP_M_P3, OP_M_SIL,
      OP_M_OUT: begin
        macc <= '0;
        mdig <= 2'd0;
        case (cmd.op)
          OP_M_SIG: begin
            ma <= 40'(sx_abs);
            mb <= 48'(19'd262144 - 19'(sx_abs));
            msign <= sx[43];
          end
          OP_M_X2: begin
            ma <= 40'(up_abs[13:0]);
            mb <= 48'(up_abs[13:0]);
            msign <= 1'b0;
          end
          OP_M_NUM: begin
            ma <= 40'(up_abs[13:0]);
            mb <= 48'(C27 + 30'(x2));
            msign <= 1'b0;
          end
          OP_M_P1: begin
            ma <= 40'(15'd16384 - s_r);
            mb <= 48'(hp_abs);
            msign <= hp[15];
          end
          OP_M_P2: begin
            ma <= 40'(p1);
            mb <= 48'(decay_r);
            msign <= p1neg;
          end
          OP_M_P3: begin
            ma <= 40'(s_r);
            mb <= 48'(t_abs);
            msign <= t_r[15];
          end
          OP_M_SIL: begin
            ma <= gate_abs;
            mb <= 48'(sg_r);
            msign <= gate_sum[39];
          end
          default: begin
            ma <= sil_abs;
            if (mode_r == MODE_RNN) begin
              mb <= 48'(hn_abs);
              msign <= sil[40] ^ hn_r[15];
            end else begin
              mb <= 48'(up_abs);
              msign <= sil[40] ^ up_sum[39];
            end
          end
        endcase
      end
      OP_MUL: begin
        macc <= macc + pp_sh;
        mdig <= mdig + 2'd1;
      end
      OP_W_S:  s_r <= sig_val;
      OP_W_SG: sg_r <= sig_val;
      OP_W_X2: x2 <= macc[27:0];
      OP_W_NUM: begin
        drem <= 47'({macc[42:0], 2'b00}) + 47'(den >> 1);
        dsh  <= 47'(den) << 15;
        dq   <= 16'd0;
        dcnt <= 4'd15;
      end
      OP_DIV: begin
        if (dfit) drem <= drem - dsh;
        dsh  <= dsh >> 1;
        dq   <= {dq[14:0], dfit};
        dcnt <= dcnt - 4'd1;
      end
      OP_W_T: begin
        if (up_sum < -40'sd12288)     t_r <= -16'sd16384;
        else if (up_sum > 40'sd12288) t_r <= 16'sd16384;
        else if (up_sum[39])          t_r <= 16'(-dq);
        else                          t_r <= 16'(dq);
      end
      OP_W_P1: begin
        p1    <= macc[30:0];
        p1neg <= msign;
      end
      OP_W_P2: t1 <= msign ? -48'($signed({1'b0, macc[46:0]}))
                           :  48'($signed({1'b0, macc[46:0]}));
      OP_W_P3: acc_r <= 49'(t1) + term2;
      OP_W_HN: hn_r <= hn_val;
      OP_W_SIL: sil <= msign ? -41'($signed({1'b0, sil_sum[53:14]}))
                             :  41'($signed({1'b0, sil_sum[53:14]}));
      OP_W_OUT: begin
        value     <= out_val;
        layer_out <= layer_r;
        row_out   <= row_r;
      end
      default: ;
    endcase
  end

endmodule

[hw/rtl/ternary_cfc_ffn_neuron_unit.sv]
// Top level of the ternary recurrent FFN neuron unit.
// Each transaction carries four Q11.12 activations with one byte of ternary
// gate codes and one of up codes; a transaction without last leaves the input
// open. The transaction with last starts the row finish, during which in_stall
// is high; the recurrent neuron finish is longer when tanh takes the 16-step
// divider, and the finish also waits while the previous result is still held
// by out_stall. The finish runs on one shared 40x16 multiplier that builds
// each product from three 16-bit digits and a one-bit-per-cycle divider.
// After reset a clearing pass writes zero to every hidden store entry, one per
// cycle, LAYER_COUNT*ROW_COUNT entries (65536 by default), before the first
// transaction is taken. The result register lets the next row start while a
// result still waits.
`include "ternary_cfc_ffn_neuron_unit_assert.svh"

module ternary_cfc_ffn_neuron_unit
  import tcfn_pkg::*;
#(
  parameter int ROW_COUNT   = 4096,
  parameter int LAYER_COUNT = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         mode,
  input  logic signed [23:0] act_0,
  input  logic signed [23:0] act_1,
  input  logic signed [23:0] act_2,
  input  logic signed [23:0] act_3,
  input  logic [7:0]         gate_trits,
  input  logic [7:0]         up_trits,
  input  logic [3:0]         layer_index,
  input  logic [11:0]        row_index,
  input  logic [15:0]        decay_factor,
  input  logic signed [15:0] neuron_bias,
  input  logic               last,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] value,
  output logic [3:0]         layer_out,
  output logic [11:0]        row_out
);

  ctl_cmd_t cmd;
  dp_stat_t stat;

  // Sequencer
  tcfn_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .last     (last),
    .mode     (mode),
    .in_stall (in_stall),
    .cmd      (cmd),
    .stat     (stat)
  );

  // Datapath
  tcfn_dp #(
    .ROW_COUNT   (ROW_COUNT),
    .LAYER_COUNT (LAYER_COUNT)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .mode         (mode),
    .act_0        (act_0),
    .act_1        (act_1),
    .act_2        (act_2),
    .act_3        (act_3),
    .gate_trits   (gate_trits),
    .up_trits     (up_trits),
    .layer_index  (layer_index),
    .row_index    (row_index),
    .decay_factor (decay_factor),
    .neuron_bias  (neuron_bias),
    .last         (last),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .value        (value),
    .layer_out    (layer_out),
    .row_out      (row_out)
  );

  // A row end starts the finish; other transactions keep the input open
  `TCFN_ASSERT_NEXT(a_last_stalls, in_valid && !in_stall && last, in_stall,
                    "row end did not start the finish")
  `TCFN_ASSERT_NEXT(a_mid_open, in_valid && !in_stall && !last, !in_stall,
                    "input closed after a mid-row transaction")
  // A result appears only at the end of a finish
  `TCFN_ASSERT_NOW(a_result_from_finish, $rose(out_valid), $past(in_stall),
                   "result appeared without a row finish")

endmodule

[sim/tcfn_checker.sv]
// Watches both channels of the neuron unit, predicts every row result and compares.
module tcfn_checker
  import tcfn_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [1:0]         mode,
  input  logic signed [23:0] act_0,
  input  logic signed [23:0] act_1,
  input  logic signed [23:0] act_2,
  input  logic signed [23:0] act_3,
  input  logic [7:0]         gate_trits,
  input  logic [7:0]         up_trits,
  input  logic [3:0]         layer_index,
  input  logic [11:0]        row_index,
  input  logic [15:0]        decay_factor,
  input  logic signed [15:0] neuron_bias,
  input  logic               last,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic signed [31:0] value,
  input  logic [3:0]         layer_out,
  input  logic [11:0]        row_out,
  output int                 fails,
  output int                 pending
);

  localparam longint SUM_MAX = 64'sd549755813887;
  localparam longint SUM_MIN = -64'sd549755813888;
  localparam longint ONE_Q14 = 16384;
  localparam longint I32_MAX = 64'sd2147483647;
  localparam longint I32_MIN = -64'sd2147483648;

  typedef struct {
    logic signed [31:0] value;
    logic [3:0]         layer;
    logic [11:0]        row;
  } row_result_t;

  row_result_t   row_results[$];
  logic signed [15:0] hidden[int];
  longint        gate_acc, up_acc;

  function automatic longint clamp(longint v, longint lo, longint hi);
    return v > hi ? hi : (v < lo ? lo : v);
  endfunction

  // round to nearest, half away from zero, dividing by 2^k
  function automatic longint round_shift(longint v, int k);
    longint unsigned m;
    m = v < 0 ? -v : v;
    m = (m + (64'd1 << (k - 1))) >> k;
    return v < 0 ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint round_div(longint num, longint den);
    longint unsigned m;
    m = num < 0 ? -num : num;
    m = (m + den / 2) / den;
    return num < 0 ? -longint'(m) : longint'(m);
  endfunction

  // Q15 in, Q14 out
  function automatic longint sigmoid_q14(longint x);
    longint ax;
    if (x < -131072) return 0;
    if (x > 131072) return ONE_Q14;
    ax = x < 0 ? -x : x;
    return 8192 + round_shift(x * (262144 - ax), 21);
  endfunction

  // Q12 in, Q14 out
  function automatic longint tanh_q14(longint x);
    longint x2, c27;
    c27 = longint'(27) << 24;
    if (x < -12288) return -ONE_Q14;
    if (x > 12288) return ONE_Q14;
    x2 = x * x;
    return round_div(x * (c27 + x2) * 4, c27 + 9 * x2);
  endfunction

  function automatic longint silu_q12(longint g);
    return round_shift(g * sigmoid_q14(g * 8), 14);
  endfunction

  // saturated Q12 product, split so nothing overflows 64 bits
  function automatic longint gated_product(longint a, longint b);
    longint unsigned ma, mb, hi, m;
    logic neg;
    ma  = a < 0 ? -a : a;
    mb  = b < 0 ? -b : b;
    neg = (a < 0) != (b < 0);
    hi  = ma * (mb >> 20);
    if (hi >= (64'd1 << 24)) return neg ? I32_MIN : I32_MAX;
    m = (hi << 8) + ((ma * (mb & 64'hFFFFF) + 2048) >> 12);
    if (neg) return m > (64'd1 << 31) ? I32_MIN : -longint'(m);
    return m > I32_MAX ? I32_MAX : longint'(m);
  endfunction

  function automatic longint ternary_add(longint s, longint a, logic [1:0] code);
    if (code == W_PLUS) return clamp(s + a, SUM_MIN, SUM_MAX);
    if (code == W_MINUS) return clamp(s - a, SUM_MIN, SUM_MAX);
    return s;
  endfunction

  // Advance the row sums and, on last, work out the row result
  task automatic predict_transaction();
    longint acts[4];
    longint hp, s, t, acc, hn, res;
    int addr;
    row_result_t r;
    acts = '{act_0, act_1, act_2, act_3};
    for (int l = 0; l < 4; l++) begin
      gate_acc = ternary_add(gate_acc, acts[l], gate_trits[2*l +: 2]);
      if (mode == MODE_RNN || mode == MODE_GATED)
        up_acc = ternary_add(up_acc, acts[l], up_trits[2*l +: 2]);
    end
    if (!last) return;
    if (mode == MODE_RNN) begin
      addr = {layer_index, row_index};
      hp   = hidden.exists(addr) ? longint'(hidden[addr]) : 0;
      s    = sigmoid_q14(up_acc * 8 + hp + longint'(neuron_bias) * 2);
      t    = tanh_q14(up_acc);
      acc  = (ONE_Q14 - s) * hp * longint'(decay_factor) + s * t * 65536;
      hn   = clamp(round_shift(acc, 30), -32768, 32767);
      hidden[addr] = hn;
      res  = clamp(round_shift(silu_q12(gate_acc) * hn, 14), I32_MIN, I32_MAX);
    end else if (mode == MODE_GATED) begin
      res = gated_product(silu_q12(gate_acc), up_acc);
    end else begin
      res = clamp(gate_acc, I32_MIN, I32_MAX);
    end
    r.value = res;
    r.layer = layer_index;
    r.row   = row_index;
    row_results.push_back(r);
    gate_acc = 0;
    up_acc   = 0;
  endtask

  assign pending = row_results.size();

  // Predict on input transactions, compare on output transactions
  always @(posedge clk) begin
    row_result_t e;
    if (rst) begin
      gate_acc <= 0;
      up_acc   <= 0;
      fails    <= 0;
      row_results.delete();
      hidden.delete();
    end else begin
      if (in_valid && !in_stall) predict_transaction();
      if (out_valid && !out_stall) begin
        if (row_results.size() == 0) begin
          $display("%0t: unexpected result value=%0d layer=%0d row=%0d",
                   $time, value, layer_out, row_out);
          fails <= fails + 1;
        end else begin
          e = row_results.pop_front();
          if (e.value !== value || e.layer !== layer_out || e.row !== row_out) begin
            $display("%0t: mismatch expected value=%0d layer=%0d row=%0d, got %0d %0d %0d",
                     $time, e.value, e.layer, e.row, value, layer_out, row_out);
            fails <= fails + 1;
          end
        end
      end
    end
  end

endmodule

[sim/tb.sv]
// Testbench top for the neuron unit: stimulus, idling and verdict.
module tb
  import tcfn_pkg::*;
;

  localparam logic [1:0] MODE_DOT     = 2'd2;
  localparam logic [1:0] MODE_DOT_ALT = 2'd3;
  localparam logic signed [23:0] ACT_MAX = 24'sh7FFFFF;
  localparam logic signed [23:0] ACT_MIN = -24'sh800000;

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0, out_stall = 0;
  logic in_stall, out_valid;
  logic [1:0] mode = 0;
  logic signed [23:0] act_0 = 0, act_1 = 0, act_2 = 0, act_3 = 0;
  logic [7:0] gate_trits = 0, up_trits = 0;
  logic [3:0] layer_index = 0;
  logic [11:0] row_index = 0;
  logic [15:0] decay_factor = 0;
  logic signed [15:0] neuron_bias = 0;
  logic last = 0;
  logic signed [31:0] value;
  logic [3:0] layer_out;
  logic [11:0] row_out;
  int fails, pending;
  logic quiet = 0;
  int stall_left = 0;

  always #5 clk = ~clk;

  ternary_cfc_ffn_neuron_unit DUT (.*);
  tcfn_checker u_checker (.*);

  // Hold off the result channel in random bursts
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_stall  <= 1;
      stall_left <= stall_left - 1;
    end else if (!quiet && $urandom_range(0, 5) == 0) begin
      out_stall  <= 1;
      stall_left <= $urandom_range(0, 5);
    end else begin
      out_stall <= 0;
    end
  end

  // Present one transaction and hold it until taken
  task automatic send(logic [1:0] m, logic signed [23:0] a0, a1, a2, a3,
                      logic [7:0] g, u, logic [3:0] ly, logic [11:0] rw,
                      logic [15:0] dc, logic signed [15:0] bs, logic lst);
    int gap;
    @(negedge clk);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_valid = 0;
      gap = $urandom_range(1, 6);
      repeat (gap) @(negedge clk);
    end
    in_valid = 1;
    mode = m; act_0 = a0; act_1 = a1; act_2 = a2; act_3 = a3;
    gate_trits = g; up_trits = u; layer_index = ly; row_index = rw;
    decay_factor = dc; neuron_bias = bs; last = lst;
    do @(posedge clk); while (in_stall);
  endtask

  function automatic logic signed [23:0] rand_act();
    case ($urandom_range(0, 5))
      0: return 24'($urandom);
      1: return $urandom_range(0, 1) ? ACT_MAX : ACT_MIN;
      default: return $signed(24'($urandom_range(0, 8191))) - 24'sd4096;
    endcase
  endfunction

  // Random row: half of them mode 0, mostly on a few reused neurons so the hidden state evolves
  task automatic random_row(output int count);
    int n;
    logic [1:0] m;
    logic [3:0] ly;
    logic [11:0] rw;
    n  = $urandom_range(0, 9) == 0 ? $urandom_range(6, 12) : $urandom_range(1, 4);
    m  = $urandom_range(0, 9) < 5 ? MODE_RNN : 2'($urandom_range(1, 3));
    ly = $urandom_range(0, 3) == 0 ? 4'($urandom) : 4'($urandom_range(0, 1));
    rw = $urandom_range(0, 3) == 0 ? 12'($urandom) : 12'($urandom_range(0, 2));
    for (int i = 0; i < n; i++)
      send(i == n - 1 ? m : 2'($urandom), rand_act(), rand_act(), rand_act(),
           rand_act(), 8'($urandom), 8'($urandom), ly, rw, 16'($urandom),
           16'($urandom), i == n - 1);
    count = n;
  endtask

  // Row of identical full-scale items to drive the sums past the 32-bit result range
  task automatic saturate_row(logic [7:0] codes, logic [1:0] m);
    for (int i = 0; i < 80; i++)
      send(i == 79 ? m : MODE_GATED, ACT_MAX, ACT_MAX, ACT_MAX, ACT_MAX, codes, codes,
           4'd3, 12'd9, 16'hFFFF, 16'sd0, i == 79 ? 1'b1 : 1'b0);
  endtask

  initial begin
    int sent;
    int n;
    repeat (11) @(posedge clk);
    @(negedge clk) rst = 0;

    // Directed: extremes, every mode, mixed modes, plain dot with up codes
    send(MODE_DOT, ACT_MAX, ACT_MIN, ACT_MAX, ACT_MIN, 8'h55, 8'hAA, 0, 0, 0, 0, 1);
    send(MODE_DOT_ALT, ACT_MIN, ACT_MIN, ACT_MIN, ACT_MIN, 8'hAA, 8'h55, 0, 0, 0, 0, 1);
    send(MODE_GATED, ACT_MAX, ACT_MAX, ACT_MAX, ACT_MAX, 8'h55, 8'h55, 0, 0, 0, 0, 1);
    send(MODE_GATED, ACT_MIN, 0, 0, 0, 8'hFF, 8'h02, 0, 0, 0, 0, 1);
    send(MODE_RNN, 24'sd4096, 24'sd2000, 0, 0, 8'h05, 8'h05, 4'd15, 12'd4095,
         16'hFFFF, 16'sh7FFF, 1);
    send(MODE_RNN, 24'sd4096, 24'sd2000, 0, 0, 8'h05, 8'h05, 4'd15, 12'd4095,
         16'hFFFF, -16'sh8000, 1);
    send(MODE_RNN, 24'sd100, 0, 0, 0, 8'h01, 8'h02, 4'd15, 12'd4095, 16'd0, 0, 1);
    send(MODE_RNN, ACT_MAX, 0, 0, 0, 8'h01, 8'h01, 4'd0, 12'd0, 16'hFFFF, 0, 1);
    send(MODE_RNN, ACT_MIN, 0, 0, 0, 8'h02, 8'h01, 4'd0, 12'd0, 16'h8000, 0, 1);
    send(MODE_DOT, 24'sd5000, 24'sd7000, 0, 0, 8'h0F, 8'hFF, 4'd1, 12'd1, 0, 0, 0);
    send(MODE_GATED, 24'sd3000, 0, 24'sd8000, 0, 8'h11, 8'h33, 4'd1, 12'd1, 0, 0, 0);
    send(MODE_RNN, 24'sd1000, 24'sd1000, 0, 0, 8'h05, 8'h09, 4'd1, 12'd1,
         16'hC000, 16'sd4000, 1);
    send(MODE_GATED, 24'sd500, 0, 0, 0, 8'h01, 8'h01, 4'd2, 12'd7, 0, 0, 0);
    send(MODE_DOT, 24'sd500, 0, 0, 0, 8'h01, 8'h01, 4'd2, 12'd7, 0, 0, 1);

    saturate_row(8'h55, MODE_GATED);
    saturate_row(8'hAA, MODE_DOT);

    // Random rows, then a tail without idling
    sent = 0;
    while (sent < 720) begin
      if (sent > 620) quiet = 1;
      random_row(n);
      sent = sent + n;
    end
    @(negedge clk) in_valid = 0;

    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (fails == 0)
      $display("** ternary_cfc_ffn_neuron_unit: PASSED **");
    else
      $display("** ternary_cfc_ffn_neuron_unit: FAILED **");
    $finish;
  end

  initial begin
    #20000000;
    $display("** ternary_cfc_ffn_neuron_unit: FAILED **");
    $finish;
  end

endmodule
